// ===== hdl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int DATA_BITS_DEF = 32;

	localparam int OP_BITS      = 2;
	localparam int KEY_BITS     = 31;
	localparam int IN_DATA_BITS = 32;
	localparam int STATUS_BITS  = 2;
	localparam int OCC_BITS     = 5;

	// Stream payload widths, padded to whole bytes
	localparam int S_TDATA_BITS = 64;
	localparam int M_TDATA_BITS = 40;

	typedef enum logic [OP_BITS-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2
	} op_e_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_MISSING = 2'd3
	} status_e_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_DONE
	} state_e_t;

	typedef struct packed {
		status_e_t                 status;
		logic [IN_DATA_BITS-1:0]   data;
		logic [OCC_BITS-1:0]       occ;
	} result_t;

endpackage

// ===== hdl/lpht_home.sv =====
// ----------------------------------------------------------------------------
// lpht_home
// Home slot of a key: key modulo SLOTS. A mask for a power-of-two slot count,
// otherwise a multiply by the reciprocal of the slot count followed by one
// compare and subtract.
// ----------------------------------------------------------------------------
module lpht_home #(
	parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lpht_pkg::KEY_BITS-1:0]     key,
	output logic                              done,
	output logic [$clog2(SLOTS)-1:0]          home
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int KEY_W = lpht_pkg::KEY_BITS;
	localparam bit POW2  = (SLOTS & (SLOTS - 1)) == 0;

	logic             done_q;
	logic [IDX_W-1:0] rem_q;

	assign done = done_q;
	assign home = rem_q;

	generate
		if (POW2) begin : g_mask
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= key[IDX_W-1:0];
				end
			end
		end else begin : g_recip
			localparam int REM_W = IDX_W + 1;
			// floor(2^KEY_W / SLOTS): the quotient it gives is short by at most one
			localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / SLOTS);

			logic                 vld_s1, vld_s2;
			logic [REM_W-1:0]     key_s1;
			logic [REM_W-1:0]     quot_s1;
			logic [REM_W-1:0]     diff_s2;
			logic [2*KEY_W-1:0]   prod;
			logic [REM_W-1:0]     qd_low;

			assign prod = (2*KEY_W)'(key) * (2*KEY_W)'(RECIP);

			// The remainder estimate is below twice the slot count, so only the
			// low bits of quotient times slot count take part
			assign qd_low = quot_s1 * REM_W'(SLOTS);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s1 <= 1'b0;
					vld_s2 <= 1'b0;
					done_q <= 1'b0;
				end else begin
					vld_s1 <= start;
					vld_s2 <= vld_s1;
					done_q <= vld_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_s1  <= key[REM_W-1:0];
					quot_s1 <= prod[KEY_W +: REM_W];
				end
				if (vld_s1) begin
					diff_s2 <= key_s1 - qd_low;
				end
				if (vld_s2) begin
					if (diff_s2 >= REM_W'(SLOTS)) begin
						rem_q <= IDX_W'(diff_s2 - REM_W'(SLOTS));
					end else begin
						rem_q <= diff_s2[IDX_W-1:0];
					end
				end
			end
		end
	endgenerate

endmodule

// ===== hdl/lpht_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpht_ctrl
// Slot memory and probe sequencer: clears the table after reset, probes one
// slot per cycle from the home slot and, for inserts and deletes, writes the hit slot back.
// ----------------------------------------------------------------------------
module lpht_ctrl #(
	parameter int SLOTS     = lpht_pkg::SLOTS_DEF,
	parameter int DATA_BITS = lpht_pkg::DATA_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [lpht_pkg::OP_BITS-1:0]          op,
	input  logic [lpht_pkg::KEY_BITS-1:0]         key,
	input  logic [lpht_pkg::IN_DATA_BITS-1:0]     data_in,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output lpht_pkg::result_t                     res,
	output logic [$clog2(SLOTS+1)-1:0]            count
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int E_W   = 1 + lpht_pkg::KEY_BITS + DATA_BITS;

	lpht_pkg::state_e_t state_q, state_d;

	logic [IDX_W-1:0]                  clr_q;
	logic [CNT_W-1:0]                  cnt_q, cnt_d;
	logic [lpht_pkg::OP_BITS-1:0]      op_q;
	logic [lpht_pkg::KEY_BITS-1:0]     key_q;
	logic [DATA_BITS-1:0]              wdata_q;
	logic [IDX_W-1:0]                  pos_q, nxt_pos;
	logic [IDX_W-1:0]                  probe_q;
	logic [CNT_W-1:0]                  seen_q;
	lpht_pkg::result_t                 res_q;

	// Slot memory: {used, key, data}
	logic [E_W-1:0]   mem [SLOTS];
	logic [E_W-1:0]   rd_q;
	logic             rd_en, we;
	logic [IDX_W-1:0] rd_addr, wa;
	logic [E_W-1:0]   wd;

	logic                              r_used;
	logic [lpht_pkg::KEY_BITS-1:0]     r_key;
	logic [DATA_BITS-1:0]              r_data;

	logic                              home_start, home_done;
	logic [IDX_W-1:0]                  home_idx;

	logic                              early;
	lpht_pkg::status_e_t               early_st;
	logic                              hit, miss;

	lpht_home #(.SLOTS(SLOTS)) u_home (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (home_start),
		.key    (key),
		.done   (home_done),
		.home   (home_idx)
	);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign r_used = rd_q[E_W-1];
	assign r_key  = rd_q[E_W-2 -: lpht_pkg::KEY_BITS];
	assign r_data = rd_q[DATA_BITS-1:0];

	assign nxt_pos = (pos_q == IDX_W'(SLOTS - 1)) ? '0 : pos_q + 1'b1;

	assign res   = res_q;
	assign count = cnt_q;

	// Requests that finish without touching the memory
	always_comb begin
		early    = 1'b1;
		early_st = lpht_pkg::ST_DONE;
		case (op)
			lpht_pkg::OP_INSERT: begin
				early    = (cnt_q == CNT_W'(SLOTS));
				early_st = lpht_pkg::ST_FULL;
			end
			lpht_pkg::OP_DELETE, lpht_pkg::OP_SEARCH: begin
				early    = (cnt_q == '0);
				early_st = lpht_pkg::ST_EMPTY;
			end
			default: begin
				early    = 1'b1;
				early_st = lpht_pkg::ST_DONE;
			end
		endcase
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		res_valid  = 1'b0;
		home_start = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = nxt_pos;
		we         = 1'b0;
		wa         = pos_q;
		wd         = {1'b1, key_q, wdata_q};
		hit        = 1'b0;
		miss       = 1'b0;
		cnt_d      = cnt_q;
		case (state_q)
			lpht_pkg::S_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = '0;
				if (clr_q == IDX_W'(SLOTS - 1)) begin
					state_d = lpht_pkg::S_IDLE;
				end
			end
			lpht_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					// Hash the key straight off the input while it is taken
					home_start = !early;
					state_d    = early ? lpht_pkg::S_DONE : lpht_pkg::S_HASH;
				end
			end
			lpht_pkg::S_HASH: begin
				if (home_done) begin
					rd_en   = 1'b1;
					rd_addr = home_idx;
					state_d = lpht_pkg::S_PROBE;
				end
			end
			lpht_pkg::S_PROBE: begin
				// Read the next slot ahead while this one is judged
				rd_en = 1'b1;
				if (op_q == lpht_pkg::OP_INSERT) begin
					hit = !r_used;
				end else begin
					hit = r_used && (r_key == key_q);
				end
				miss = !hit && ((probe_q == IDX_W'(SLOTS - 1)) ||
					(op_q != lpht_pkg::OP_INSERT && r_used && (seen_q + 1'b1) == cnt_q));
				if (hit) begin
					case (op_q)
						lpht_pkg::OP_INSERT: begin
							we    = 1'b1;
							cnt_d = cnt_q + 1'b1;
						end
						lpht_pkg::OP_DELETE: begin
							we    = 1'b1;
							wd    = {1'b0, r_key, r_data};
							cnt_d = cnt_q - 1'b1;
						end
						default: begin
							we = 1'b0;
						end
					endcase
				end
				if (hit || miss) begin
					state_d = lpht_pkg::S_DONE;
				end
			end
			lpht_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = lpht_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lpht_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpht_pkg::S_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == lpht_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lpht_pkg::S_IDLE && in_valid) begin
			op_q         <= op;
			key_q        <= key;
			wdata_q      <= DATA_BITS'(data_in);
			res_q.status <= early_st;
			res_q.data   <= '0;
			res_q.occ    <= lpht_pkg::OCC_BITS'(cnt_q);
		end
		if (state_q == lpht_pkg::S_HASH && home_done) begin
			pos_q   <= home_idx;
			probe_q <= '0;
			seen_q  <= '0;
		end
		if (state_q == lpht_pkg::S_PROBE) begin
			if (hit || miss) begin
				res_q.status <= hit ? lpht_pkg::ST_DONE : lpht_pkg::ST_MISSING;
				res_q.data   <= (hit && op_q == lpht_pkg::OP_SEARCH) ?
					lpht_pkg::IN_DATA_BITS'(r_data) : '0;
				res_q.occ    <= lpht_pkg::OCC_BITS'(cnt_d);
			end else begin
				pos_q   <= nxt_pos;
				probe_q <= probe_q + 1'b1;
				seen_q  <= seen_q + CNT_W'(r_used);
			end
		end
	end

endmodule

// ===== hdl/linear_probe_hash_table_unit.sv =====
// An open-addressing hash table of SLOTS entries with linear probing. Each input
// item inserts, deletes or searches a key; its home slot is key modulo SLOTS and
// probing walks upward with wrap-around. One result item follows every input
// item. After reset the unit clears the slot memory, with s_axis_tready low. An
// item is then accepted, its home slot found (by a mask when SLOTS is a power of
// two, otherwise through a multiply by the reciprocal of the slot count), its
// slots visited one by one through the single read port of the slot memory (at
// most SLOTS), and its result presented. A full table, an empty table or an
// unused operation code skips the hash and the probe. Items are handled one at a
// time; the result register lets the next item enter while a result waits.
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Top level: stream ports, result register and checks.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit #(
	parameter int SLOTS     = lpht_pkg::SLOTS_DEF,
	parameter int DATA_BITS = lpht_pkg::DATA_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// key [30:0], data_in [62:31], zero [63]
	input  logic [lpht_pkg::S_TDATA_BITS-1:0]    s_axis_tdata,
	// operation [1:0]
	input  logic [lpht_pkg::OP_BITS-1:0]         s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// data_out [31:0], occupancy [36:32], zero [39:37]
	output logic [lpht_pkg::M_TDATA_BITS-1:0]    m_axis_tdata,
	// status [1:0]
	output logic [lpht_pkg::STATUS_BITS-1:0]     m_axis_tuser
);

	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int PAD_W = lpht_pkg::M_TDATA_BITS - lpht_pkg::IN_DATA_BITS - lpht_pkg::OCC_BITS;

	logic                 res_valid, res_ready;
	lpht_pkg::result_t    res;
	logic [CNT_W-1:0]     count;

	logic                 out_valid_q;
	lpht_pkg::result_t    out_q;

	lpht_ctrl #(
		.SLOTS     (SLOTS),
		.DATA_BITS (DATA_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.op        (s_axis_tuser),
		.key       (s_axis_tdata[lpht_pkg::KEY_BITS-1:0]),
		.data_in   (s_axis_tdata[lpht_pkg::KEY_BITS +: lpht_pkg::IN_DATA_BITS]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.count     (count)
	);

	// Take a new result when the register is empty or drains this cycle
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {PAD_W'(0), out_q.occ, out_q.data};

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("item accepted while another is in progress");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(SLOTS))
		else $error("entry count beyond slot count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == lpht_pkg::ST_FULL) |-> count == CNT_W'(SLOTS))
		else $error("full status on a table with free slots");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == lpht_pkg::ST_EMPTY) |-> count == '0)
		else $error("empty status on a table with entries");
`endif

endmodule
